// File: rtl/nbp_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// nbp_pkg
// Shared types and constants of the neighbor position table.
// ----------------------------------------------------------------------------
package nbp_pkg;

  localparam int SLOTS_DEF = 16;

  localparam int ID_W   = 8;
  localparam int POS_W  = 32;
  localparam int SLOT_W = 4;

  localparam logic [POS_W-1:0] NONE_FOUND = 32'hffff_ffff;

  typedef enum logic [1:0] {
    OP_REG   = 2'd0,
    OP_UNREG = 2'd1,
    OP_QUERY = 2'd2,
    OP_NONE  = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_SCAN = 3'b010,
    S_FIN  = 3'b100
  } state_t;

endpackage : nbp_pkg
`default_nettype wire

// File: rtl/neighbor_position_table.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// neighbor_position_table
// Slot table of neighbor vehicle IDs and track positions with register,
// unregister and front-distance query requests.
// ----------------------------------------------------------------------------
// A request is taken when start is high and busy is low. While it runs, the
// ID and position memories are read one slot per cycle by a single compare
// and subtract unit; an unregister clears valid flags during the scan, and a
// register request writes the table and its valid flag in the final
// cycle. The result is on status, slot and distance for the single cycle in
// which done is high; the receiver cannot stall it, so capture it then. A new
// request may be issued in that same cycle. No clearing pass is needed after
// reset: a valid flag per slot marks it occupied.
// ----------------------------------------------------------------------------
module neighbor_position_table
  import nbp_pkg::*;
#(
  parameter int SLOTS = SLOTS_DEF
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              start,
  input  wire logic [1:0]        op,
  input  wire logic [ID_W-1:0]   car_id,
  input  wire logic [POS_W-1:0]  position,
  input  wire logic [POS_W-1:0]  own_pos,
  input  wire logic              at_boarding,
  output logic                   busy,
  output logic                   done,
  output logic                   status,
  output logic [SLOT_W-1:0]      slot,
  output logic [POS_W-1:0]       distance
);

  localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int CNT_W = $clog2(SLOTS + 1);
  localparam logic [CNT_W-1:0] SLOTS_C = CNT_W'(SLOTS);

  state_t state;

  logic [ID_W-1:0]  id_mem  [SLOTS];
  logic [POS_W-1:0] pos_mem [SLOTS];
  logic [SLOTS-1:0] valid;

  logic [1:0]       op_q;
  logic [ID_W-1:0]  car_q;
  logic [POS_W-1:0] pos_q;
  logic [POS_W-1:0] own_q;
  logic             brd_q;

  logic [CNT_W-1:0] rd_cnt;
  logic [IDX_W-1:0] rd_addr;
  logic             ev_vld;
  logic [IDX_W-1:0] ev_idx;
  logic [ID_W-1:0]  id_rd;
  logic [POS_W-1:0] pos_rd;

  logic             found_match;
  logic [IDX_W-1:0] match_idx;
  logic             found_empty;
  logic [IDX_W-1:0] empty_idx;
  logic [POS_W-1:0] best;
  logic [POS_W-1:0] min_pos;

  logic [ID_W-1:0]  eff_id;
  logic             id_hit;
  logic             slot_empty;
  logic             borrow;
  logic [POS_W-1:0] diff;
  logic             ahead;
  logic             accept;
  logic             scan_end;
  logic             wr_pos;
  logic             wr_new;
  logic [IDX_W-1:0] wr_idx;
  logic [IDX_W+SLOT_W-1:0] slot_ext;

  assign accept   = start && !busy;
  assign busy     = (state != S_IDLE);
  assign rd_addr  = rd_cnt[IDX_W-1:0];
  assign scan_end = (rd_cnt == SLOTS_C) && !ev_vld;

  assign eff_id     = valid[ev_idx] ? id_rd : '0;
  assign id_hit     = (eff_id == car_q);
  assign slot_empty = !valid[ev_idx];
  assign {borrow, diff} = {1'b0, pos_rd} - {1'b0, own_q};
  assign ahead      = valid[ev_idx] && !borrow && (diff != '0);

  assign wr_pos   = (state == S_FIN) && (op_q == OP_REG) && (found_match || found_empty);
  assign wr_new   = (state == S_FIN) && (op_q == OP_REG) && !found_match && found_empty;
  assign wr_idx   = found_match ? match_idx : empty_idx;
  assign slot_ext = {{SLOT_W{1'b0}}, wr_idx};

  // memories
  always_ff @(posedge clk) begin
    id_rd  <= id_mem[rd_addr];
    pos_rd <= pos_mem[rd_addr];
    if (wr_pos) begin
      pos_mem[wr_idx] <= pos_q;
    end
    if (wr_new) begin
      id_mem[wr_idx] <= car_q;
    end
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= S_IDLE;
      valid  <= '0;
      done   <= 1'b0;
      rd_cnt <= '0;
      ev_vld <= 1'b0;
    end else begin
      done <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            state  <= S_SCAN;
            rd_cnt <= '0;
            ev_vld <= 1'b0;
          end
        end
        S_SCAN: begin
          ev_vld <= (rd_cnt < SLOTS_C);
          if (rd_cnt < SLOTS_C) begin
            rd_cnt <= rd_cnt + 1'b1;
          end
          if (ev_vld && (op_q == OP_UNREG) && id_hit) begin
            valid[ev_idx] <= 1'b0;
          end
          if (scan_end) begin
            state <= S_FIN;
          end
        end
        S_FIN: begin
          if (wr_new) begin
            valid[wr_idx] <= 1'b1;
          end
          done  <= 1'b1;
          state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // request fields, scan trackers and result
  always_ff @(posedge clk) begin
    ev_idx <= rd_addr;
    if (accept) begin
      op_q        <= op;
      car_q       <= car_id;
      pos_q       <= position;
      own_q       <= own_pos;
      brd_q       <= at_boarding;
      found_match <= 1'b0;
      found_empty <= 1'b0;
      match_idx   <= '0;
      empty_idx   <= '0;
      best        <= NONE_FOUND;
      min_pos     <= NONE_FOUND;
    end else if ((state == S_SCAN) && ev_vld) begin
      if (id_hit && !found_match) begin
        found_match <= 1'b1;
        match_idx   <= ev_idx;
      end
      if (slot_empty && !found_empty) begin
        found_empty <= 1'b1;
        empty_idx   <= ev_idx;
      end
      if (ahead && (diff < best)) begin
        best <= diff;
      end
      if (valid[ev_idx] && (pos_rd < min_pos)) begin
        min_pos <= pos_rd;
      end
    end
    if (state == S_FIN) begin
      status   <= 1'b0;
      slot     <= '0;
      distance <= '0;
      case (op_q)
        OP_REG: begin
          if (found_match || found_empty) begin
            slot <= slot_ext[SLOT_W-1:0];
          end else begin
            status <= 1'b1;
          end
        end
        OP_QUERY: begin
          distance <= (brd_q && (best == NONE_FOUND)) ? min_pos : best;
        end
        default: begin
        end
      endcase
    end
  end

  a_done_pulse : assert property (@(posedge clk) disable iff (rst)
    done |=> !done)
    else $error("done held longer than one cycle");

  a_accept_busy : assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy)
    else $error("request accepted without going busy");

  a_done_after_busy : assert property (@(posedge clk) disable iff (rst)
    done |-> $past(busy))
    else $error("result without a request in progress");

  a_full_fields : assert property (@(posedge clk) disable iff (rst)
    (done && status) |-> ((slot == '0) && (distance == '0)))
    else $error("full result carries slot or distance");

endmodule : neighbor_position_table
`default_nettype wire

// File: tb/sv/neighbor_position_table_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// neighbor_position_table_checker
// Watches the request and result channels of the neighbor position table.
// Keeps its own copy of the slot table, works out the outcome of every
// accepted request, and compares each done strobe against the oldest
// outstanding outcome field by field.
// ----------------------------------------------------------------------------
module neighbor_position_table_checker
  import nbp_pkg::*;
#(
  parameter int SLOTS = SLOTS_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic              busy,
  input  logic [1:0]        op,
  input  logic [ID_W-1:0]   car_id,
  input  logic [POS_W-1:0]  position,
  input  logic [POS_W-1:0]  own_pos,
  input  logic              at_boarding,
  input  logic              done,
  input  logic              status,
  input  logic [SLOT_W-1:0] slot,
  input  logic [POS_W-1:0]  distance,
  output int                fail_count,
  output int                pending
);

  typedef struct packed {
    logic              status;
    logic [SLOT_W-1:0] slot;
    logic [POS_W-1:0]  distance;
  } outcome_t;

  logic [ID_W-1:0]  id_tab  [SLOTS];
  logic [POS_W-1:0] pos_tab [SLOTS];
  outcome_t         outcome_q [$];

  function automatic outcome_t apply_request(op_t code, logic [ID_W-1:0] id,
                                             logic [POS_W-1:0] pos,
                                             logic [POS_W-1:0] own, logic brd);
    outcome_t         res;
    logic             hit;
    logic [POS_W-1:0] best;
    logic [POS_W-1:0] gap;
    res = '0;
    hit = 1'b0;
    case (code)
      OP_REG: begin
        for (int k = 0; k < SLOTS; k++) begin
          if (!hit && id_tab[k] == id) begin
            pos_tab[k] = pos;
            res.slot   = k[SLOT_W-1:0];
            hit        = 1'b1;
          end
        end
        for (int k = 0; k < SLOTS; k++) begin
          if (!hit && id_tab[k] == '0) begin
            id_tab[k]  = id;
            pos_tab[k] = pos;
            res.slot   = k[SLOT_W-1:0];
            hit        = 1'b1;
          end
        end
        if (!hit) res.status = 1'b1;
      end
      OP_UNREG: begin
        for (int k = 0; k < SLOTS; k++) begin
          if (id_tab[k] == id) id_tab[k] = '0;
        end
      end
      OP_QUERY: begin
        best = NONE_FOUND;
        for (int k = 0; k < SLOTS; k++) begin
          if (id_tab[k] != '0 && own < pos_tab[k]) begin
            gap = pos_tab[k] - own;
            if (gap < best) best = gap;
          end
        end
        // at boarding, fall back to the lowest occupied position when nothing lies ahead
        if (brd && best == NONE_FOUND) begin
          for (int k = 0; k < SLOTS; k++) begin
            if (id_tab[k] != '0 && pos_tab[k] < best) best = pos_tab[k];
          end
        end
        res.distance = best;
      end
      default: ;
    endcase
    return res;
  endfunction

  always @(posedge clk) begin : watch
    outcome_t want;
    if (rst) begin
      for (int k = 0; k < SLOTS; k++) begin
        id_tab[k]  = '0;
        pos_tab[k] = '0;
      end
      outcome_q.delete();
      pending <= 0;
    end else begin
      if (done) begin
        if (outcome_q.size() == 0) begin
          $error("result with no request outstanding");
          fail_count++;
        end else begin
          want = outcome_q.pop_front();
          if (status !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, status);
            fail_count++;
          end
          if (slot !== want.slot) begin
            $error("slot: expected %0d, got %0d", want.slot, slot);
            fail_count++;
          end
          if (distance !== want.distance) begin
            $error("distance: expected %h, got %h", want.distance, distance);
            fail_count++;
          end
        end
      end
      if (start && !busy) begin
        outcome_q.push_back(apply_request(op_t'(op), car_id, position, own_pos,
                                          at_boarding));
      end
      pending <= outcome_q.size();
    end
  end

endmodule : neighbor_position_table_checker

// File: tb/sv/neighbor_position_table_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// neighbor_position_table_tb
// Drives register, unregister, query and unused requests into the neighbor
// position table: a directed opening over empty, full and boundary cases,
// then random traffic over small ID pools so the table fills and drains.
// A checker beside the block predicts and compares every result.
// ----------------------------------------------------------------------------
module neighbor_position_table_tb;
  import nbp_pkg::*;

  localparam int SLOTS      = SLOTS_DEF;
  localparam int CLK_PERIOD = 12;
  localparam int BLOCKS     = 8;
  localparam int BLOCK_LEN  = 100;

  logic              clk;
  logic              rst         = 1'b1;
  logic              start       = 1'b0;
  logic [1:0]        op          = OP_REG;
  logic [ID_W-1:0]   car_id      = '0;
  logic [POS_W-1:0]  position    = '0;
  logic [POS_W-1:0]  own_pos     = '0;
  logic              at_boarding = 1'b0;
  logic              busy;
  logic              done;
  logic              status;
  logic [SLOT_W-1:0] slot;
  logic [POS_W-1:0]  distance;
  int                fail_count;
  int                pending;

  int  n_reg;
  int  n_unreg;
  int  n_query;
  int  n_other;
  bit  no_idle;

  neighbor_position_table #(.SLOTS(SLOTS)) DUT (
    .clk(clk), .rst(rst), .start(start), .op(op), .car_id(car_id),
    .position(position), .own_pos(own_pos), .at_boarding(at_boarding),
    .busy(busy), .done(done), .status(status), .slot(slot), .distance(distance)
  );

  neighbor_position_table_checker #(.SLOTS(SLOTS)) u_checker (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .op(op), .car_id(car_id),
    .position(position), .own_pos(own_pos), .at_boarding(at_boarding),
    .done(done), .status(status), .slot(slot), .distance(distance),
    .fail_count(fail_count), .pending(pending)
  );

  initial begin
    clk = 1'b0;
    forever #(CLK_PERIOD / 2) clk = ~clk;
  end

  function automatic int pick_gap();
    int r;
    if (no_idle) return 0;
    r = $urandom_range(0, 99);
    if (r < 65) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic logic [POS_W-1:0] pick_pos(logic [POS_W-1:0] base);
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) return $urandom;
    if (r == 1) return $urandom_range(0, 1) ? NONE_FOUND : '0;
    return base + $urandom_range(0, 2000);
  endfunction

  task automatic issue_request(op_t code, logic [ID_W-1:0] id, logic [POS_W-1:0] pos,
                               logic [POS_W-1:0] own, logic brd);
    int gap;
    start       <= 1'b1;
    op          <= code;
    car_id      <= id;
    position    <= pos;
    own_pos     <= own;
    at_boarding <= brd;
    do @(posedge clk); while (busy);
    case (code)
      OP_REG:   n_reg++;
      OP_UNREG: n_unreg++;
      OP_QUERY: n_query++;
      default:  n_other++;
    endcase
    gap = pick_gap();
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic drain();
    start <= 1'b0;
    do @(posedge clk); while (pending != 0);
  endtask

  initial begin : stimulus
    op_t              code;
    logic [ID_W-1:0]  id;
    logic [POS_W-1:0] base;
    int               pool;
    int               sel;
    n_reg   = 0;
    n_unreg = 0;
    n_query = 0;
    n_other = 0;
    no_idle = 1'b0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // empty table, null IDs and the unused opcode
    issue_request(OP_QUERY, 8'd0, $urandom, 32'd0, 1'b1);
    issue_request(OP_UNREG, 8'd0, $urandom, $urandom, 1'b0);
    issue_request(OP_NONE, ID_W'($urandom), $urandom, $urandom, 1'($urandom_range(0, 1)));
    issue_request(OP_REG, 8'd0, 32'h0000_1234, $urandom, 1'b0);
    // extremes of ID and position, distance of all ones ahead
    issue_request(OP_REG, 8'd255, NONE_FOUND, $urandom, 1'b0);
    issue_request(OP_REG, 8'd1, 32'd0, $urandom, 1'b0);
    issue_request(OP_QUERY, ID_W'($urandom), $urandom, 32'd0, 1'b0);
    issue_request(OP_QUERY, ID_W'($urandom), $urandom, 32'd0, 1'b1);
    issue_request(OP_REG, 8'd1, 32'd500, $urandom, 1'b0);
    issue_request(OP_QUERY, ID_W'($urandom), $urandom, 32'd100, 1'b0);
    issue_request(OP_QUERY, ID_W'($urandom), $urandom, 32'd500, 1'b0);
    issue_request(OP_QUERY, ID_W'($urandom), $urandom, NONE_FOUND, 1'b1);
    issue_request(OP_UNREG, 8'd255, $urandom, $urandom, 1'b0);
    // fill to capacity, then overflow with a new ID and with ID zero
    for (int n = 2; n <= SLOTS + 1; n++) begin
      issue_request(OP_REG, n[ID_W-1:0], $urandom, $urandom, 1'b0);
    end
    issue_request(OP_REG, 8'd0, $urandom, $urandom, 1'b0);
    issue_request(OP_QUERY, ID_W'($urandom), $urandom, $urandom, 1'b1);
    drain();

    for (int b = 0; b < BLOCKS; b++) begin
      pool    = $urandom_range(3, 40);
      base    = $urandom;
      no_idle = (b == 2 || b == 5);
      for (int i = 0; i < BLOCK_LEN; i++) begin
        sel = $urandom_range(0, 99);
        if (sel < 45)      code = OP_REG;
        else if (sel < 70) code = OP_UNREG;
        else if (sel < 95) code = OP_QUERY;
        else               code = OP_NONE;
        sel = $urandom_range(0, 19);
        if (sel == 0)      id = ID_W'($urandom);
        else if (sel == 1) id = '0;
        else               id = ID_W'($urandom_range(1, pool));
        issue_request(code, id, pick_pos(base), pick_pos(base),
                      1'($urandom_range(0, 1)));
      end
      // hold off until the table has answered everything
      drain();
    end

    drain();
    repeat (SLOTS + 8) @(posedge clk);
    if (pending != 0) $error("%0d results never arrived", pending);
    $display("Sent %0d register, %0d unregister, %0d query and %0d unused requests",
             n_reg, n_unreg, n_query, n_other);
    $display("Covered empty and full table, null IDs, wraparound and boarding fallback");
    if (fail_count == 0 && pending == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("Mismatches found");
    $finish;
  end

endmodule : neighbor_position_table_tb
